// ===== src/i2cra_pkg.sv =====
// Package with the shared types and constants of the I2C register access master.
package i2cra_pkg;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd44;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_SDA1 = 5'd1,
		PH_ST_SCLH = 5'd2,
		PH_ST_SDA0 = 5'd3,
		PH_ST_SCLL = 5'd4,
		PH_TX_DATA = 5'd5,
		PH_TX_SCLH = 5'd6,
		PH_TX_SCLL = 5'd7,
		PH_TA_SDA1 = 5'd8,
		PH_TA_SCLH = 5'd9,
		PH_TA_SAMP = 5'd10,
		PH_TA_SCLL = 5'd11,
		PH_RX_REL  = 5'd12,
		PH_RX_SCLH = 5'd13,
		PH_RX_SCLL = 5'd14,
		PH_RA_DRV  = 5'd15,
		PH_RA_SCLH = 5'd16,
		PH_RA_SCLL = 5'd17,
		PH_RA_REL  = 5'd18,
		PH_SP_SDA0 = 5'd19,
		PH_SP_SCLH = 5'd20,
		PH_SP_SDA1 = 5'd21
	} phase_t;

	typedef enum logic [2:0] {
		STG_ADDRW = 3'd0,
		STG_REG   = 3'd1,
		STG_VAL   = 3'd2,
		STG_ADDRR = 3'd3,
		STG_DATA  = 3'd4
	} stage_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_RSVD  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] reg_addr;
		logic [7:0] write_value;
		logic [7:0] read_count;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_index;
		logic [7:0] shift_byte;
		logic [7:0] bytes_remaining;
		logic       ack_good;
		logic [7:0] latched_register;
		logic [7:0] latched_value;
		logic       read_mode;
		stage_t     stage;
		logic       scl_drive;
		logic       sda_drive;
	} bus_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last_byte;
	} res_t;

	localparam bus_state_t BUS_STATE_RESET = '{
		phase:            PH_IDLE,
		bit_index:        4'd0,
		shift_byte:       8'd0,
		bytes_remaining:  8'd0,
		ack_good:         1'b1,
		latched_register: 8'd0,
		latched_value:    8'd0,
		read_mode:        1'b0,
		stage:            STG_ADDRW,
		scl_drive:        1'b1,
		sda_drive:        1'b1
	};

endpackage

// ===== src/i2cra_step.sv =====
// Next-state and result logic for one bus tick of the I2C register access master.
module i2cra_step (
	input  i2cra_pkg::bus_state_t cur,
	input  i2cra_pkg::req_t       req,
	input  logic [6:0]            device_address,
	output i2cra_pkg::bus_state_t nxt,
	output i2cra_pkg::res_t       res
);
	import i2cra_pkg::*;

	bus_state_t st;
	logic [3:0] bit_inc;
	logic [7:0] br_dec;

	always_comb begin
		st = cur;
		if (cur.phase == PH_IDLE && (req.cmd == CMD_WRITE || req.cmd == CMD_READ)) begin
			st.read_mode        = (req.cmd == CMD_READ);
			st.latched_register = req.reg_addr;
			st.latched_value    = req.write_value;
			st.bytes_remaining  = req.read_count;
			st.ack_good         = 1'b1;
			st.stage            = STG_ADDRW;
			st.bit_index        = 4'd0;
			st.shift_byte       = 8'd0;
			st.phase            = PH_ST_SDA1;
		end

		nxt     = st;
		bit_inc = st.bit_index + 4'd1;
		br_dec  = (st.bytes_remaining != 8'd0) ? st.bytes_remaining - 8'd1
			: st.bytes_remaining;
		res     = '0;

		unique case (st.phase)
			PH_IDLE: begin
			end
			PH_ST_SDA1: begin
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_ST_SCLH;
			end
			PH_ST_SCLH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_ST_SDA0;
			end
			PH_ST_SDA0: begin
				nxt.sda_drive = 1'b0;
				nxt.phase     = PH_ST_SCLL;
			end
			PH_ST_SCLL: begin
				nxt.scl_drive  = 1'b0;
				nxt.shift_byte = {device_address, (st.stage == STG_ADDRR)};
				nxt.bit_index  = 4'd0;
				nxt.phase      = PH_TX_DATA;
			end
			PH_TX_DATA: begin
				nxt.sda_drive = st.shift_byte[7];
				nxt.phase     = PH_TX_SCLH;
			end
			PH_TX_SCLH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_TX_SCLL;
			end
			PH_TX_SCLL: begin
				nxt.scl_drive  = 1'b0;
				nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
				nxt.bit_index  = bit_inc;
				nxt.phase      = (bit_inc >= 4'd8) ? PH_TA_SDA1 : PH_TX_DATA;
			end
			PH_TA_SDA1: begin
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_TA_SCLH;
			end
			PH_TA_SCLH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_TA_SAMP;
			end
			PH_TA_SAMP: begin
				if (req.sda_in) begin
					nxt.ack_good = 1'b0;
				end
				nxt.phase = PH_TA_SCLL;
			end
			PH_TA_SCLL: begin
				nxt.scl_drive = 1'b0;
				if (st.stage == STG_ADDRW) begin
					nxt.stage      = STG_REG;
					nxt.shift_byte = st.latched_register;
					nxt.bit_index  = 4'd0;
					nxt.phase      = PH_TX_DATA;
				end else if (st.stage == STG_REG) begin
					if (st.read_mode) begin
						nxt.stage = STG_ADDRR;
						nxt.phase = PH_ST_SDA1;
					end else begin
						nxt.stage      = STG_VAL;
						nxt.shift_byte = st.latched_value;
						nxt.bit_index  = 4'd0;
						nxt.phase      = PH_TX_DATA;
					end
				end else if (st.stage == STG_ADDRR && st.ack_good
						&& st.bytes_remaining != 8'd0) begin
					nxt.stage = STG_DATA;
					nxt.phase = PH_RX_REL;
				end else begin
					nxt.phase = PH_SP_SDA0;
				end
			end
			PH_RX_REL: begin
				nxt.sda_drive  = 1'b1;
				nxt.shift_byte = 8'd0;
				nxt.bit_index  = 4'd0;
				nxt.phase      = PH_RX_SCLH;
			end
			PH_RX_SCLH: begin
				nxt.scl_drive  = 1'b1;
				nxt.shift_byte = {st.shift_byte[6:0], req.sda_in};
				nxt.phase      = PH_RX_SCLL;
			end
			PH_RX_SCLL: begin
				nxt.scl_drive = 1'b0;
				nxt.bit_index = bit_inc;
				if (bit_inc >= 4'd8) begin
					res.data_valid = 1'b1;
					res.data_byte  = st.shift_byte;
					res.last_byte  = (st.bytes_remaining == 8'd1);
					nxt.phase      = PH_RA_DRV;
				end else begin
					nxt.phase = PH_RX_SCLH;
				end
			end
			PH_RA_DRV: begin
				nxt.sda_drive = (st.bytes_remaining == 8'd1);
				nxt.phase     = PH_RA_SCLH;
			end
			PH_RA_SCLH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_RA_SCLL;
			end
			PH_RA_SCLL: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_RA_REL;
			end
			PH_RA_REL: begin
				nxt.sda_drive       = 1'b1;
				nxt.bytes_remaining = br_dec;
				nxt.phase           = (br_dec == 8'd0) ? PH_SP_SDA0 : PH_RX_REL;
			end
			PH_SP_SDA0: begin
				nxt.sda_drive = 1'b0;
				nxt.phase     = PH_SP_SCLH;
			end
			PH_SP_SCLH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_SP_SDA1;
			end
			PH_SP_SDA1: begin
				nxt.sda_drive = 1'b1;
				res.done_res  = 1'b1;
				res.success   = st.ack_good;
				nxt.phase     = PH_IDLE;
			end
			default: begin
				nxt.scl_drive = 1'b1;
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_IDLE;
			end
		endcase

		res.scl_level = nxt.scl_drive;
		res.sda_level = nxt.sda_drive;
		res.busy_res  = (nxt.phase != PH_IDLE);
	end

endmodule

// ===== src/i2c_register_access_master_top.sv =====
// Top level of the I2C register access master: input register, bus state and result register.
//
// Each input beat is one bus tick. A beat is registered in the input register, stepped through the bus
// state machine combinationally, and its result beat is registered in the output register. The block
// takes one beat per cycle whenever the output side takes its results. The rate is set by the bus state
// register, which is updated once per tick. The device address register must be written with cfg_we
// only while no transaction is in progress; the block itself does not enforce this.
module i2c_register_access_master_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] reg_addr,
	input  logic [7:0] write_value,
	input  logic [7:0] read_count,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic       busy_res,
	output logic       done_res,
	output logic       success,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic       last_byte
);
	import i2cra_pkg::*;

	logic [6:0] dev_addr_q;
	bus_state_t bus_q;
	bus_state_t bus_nxt;
	req_t       req_s1;
	logic       valid_s1;
	res_t       res_c;
	res_t       res_s2;
	logic       valid_s2;
	logic       advance;

	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RESET;
		end else if (cfg_we) begin
			dev_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= '{
				cmd:         cmd_t'(cmd),
				reg_addr:    reg_addr,
				write_value: write_value,
				read_count:  read_count,
				sda_in:      sda_in
			};
		end
	end

	i2cra_step u_step (
		.cur            (bus_q),
		.req            (req_s1),
		.device_address (dev_addr_q),
		.nxt            (bus_nxt),
		.res            (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= BUS_STATE_RESET;
		end else if (valid_s1 && advance) begin
			bus_q <= bus_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid  = valid_s2;
	assign scl_level  = res_s2.scl_level;
	assign sda_level  = res_s2.sda_level;
	assign busy_res   = res_s2.busy_res;
	assign done_res   = res_s2.done_res;
	assign success    = res_s2.success;
	assign data_byte  = res_s2.data_byte;
	assign data_valid = res_s2.data_valid;
	assign last_byte  = res_s2.last_byte;

endmodule

// ===== tb/tb_i2c_register_access_master_top.sv =====
// Self-checking testbench for the I2C register access master, with a tick-level bus predictor.
`timescale 1ns / 1ps

module tb_i2c_register_access_master_top;
	import i2cra_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_TICKS = 240;
	localparam int RANDOM_PHASES = 3;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = DEVICE_ADDRESS_RESET;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] cmd = CMD_TICK;
	logic [7:0] reg_addr = 8'd0;
	logic [7:0] write_value = 8'd0;
	logic [7:0] read_count = 8'd0;
	logic       sda_in = 1'b1;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic       success;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       last_byte;

	bus_state_t line_state = BUS_STATE_RESET;
	logic [6:0] addr_shadow = DEVICE_ADDRESS_RESET;
	res_t       tick_results_q[$];
	int         error_count = 0;
	int         result_count = 0;
	int         work_ticks = 0;
	int         idle_cycles = 0;
	int         hold_left = 0;
	bit         stalls_on = 1'b1;

	i2c_register_access_master_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.reg_addr(reg_addr),
		.write_value(write_value),
		.read_count(read_count),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.busy_res(busy_res),
		.done_res(done_res),
		.success(success),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.last_byte(last_byte)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!stalls_on || r < 65)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic string show_result(input res_t r);
		return $sformatf("scl %0b sda %0b busy %0b done %0b ok %0b byte %02h valid %0b last %0b",
			r.scl_level, r.sda_level, r.busy_res, r.done_res, r.success, r.data_byte,
			r.data_valid, r.last_byte);
	endfunction

	// Advances the bus state by one tick and returns the line drive and flags it produces.
	function automatic res_t step_i2c_tick(input req_t t);
		bus_state_t s;
		res_t r;
		s = line_state;
		r = '0;
		if (s.phase == PH_IDLE && (t.cmd == CMD_WRITE || t.cmd == CMD_READ)) begin
			s.read_mode = (t.cmd == CMD_READ);
			s.latched_register = t.reg_addr;
			s.latched_value = t.write_value;
			s.bytes_remaining = t.read_count;
			s.ack_good = 1'b1;
			s.stage = STG_ADDRW;
			s.bit_index = 4'd0;
			s.shift_byte = 8'd0;
			s.phase = PH_ST_SDA1;
		end
		case (s.phase)
			PH_IDLE: ;
			PH_ST_SDA1: begin
				s.sda_drive = 1'b1;
				s.phase = PH_ST_SCLH;
			end
			PH_ST_SCLH: begin
				s.scl_drive = 1'b1;
				s.phase = PH_ST_SDA0;
			end
			PH_ST_SDA0: begin
				s.sda_drive = 1'b0;
				s.phase = PH_ST_SCLL;
			end
			PH_ST_SCLL: begin
				s.scl_drive = 1'b0;
				s.shift_byte = {addr_shadow, s.stage == STG_ADDRR};
				s.bit_index = 4'd0;
				s.phase = PH_TX_DATA;
			end
			PH_TX_DATA: begin
				s.sda_drive = s.shift_byte[7];
				s.phase = PH_TX_SCLH;
			end
			PH_TX_SCLH: begin
				s.scl_drive = 1'b1;
				s.phase = PH_TX_SCLL;
			end
			PH_TX_SCLL: begin
				s.scl_drive = 1'b0;
				s.shift_byte = s.shift_byte << 1;
				s.bit_index = s.bit_index + 4'd1;
				s.phase = (s.bit_index >= 4'd8) ? PH_TA_SDA1 : PH_TX_DATA;
			end
			PH_TA_SDA1: begin
				s.sda_drive = 1'b1;
				s.phase = PH_TA_SCLH;
			end
			PH_TA_SCLH: begin
				s.scl_drive = 1'b1;
				s.phase = PH_TA_SAMP;
			end
			PH_TA_SAMP: begin
				if (t.sda_in)
					s.ack_good = 1'b0;
				s.phase = PH_TA_SCLL;
			end
			PH_TA_SCLL: begin
				s.scl_drive = 1'b0;
				if (s.stage == STG_ADDRW) begin
					s.stage = STG_REG;
					s.shift_byte = s.latched_register;
					s.bit_index = 4'd0;
					s.phase = PH_TX_DATA;
				end else if (s.stage == STG_REG && s.read_mode) begin
					s.stage = STG_ADDRR;
					s.phase = PH_ST_SDA1;
				end else if (s.stage == STG_REG) begin
					s.stage = STG_VAL;
					s.shift_byte = s.latched_value;
					s.bit_index = 4'd0;
					s.phase = PH_TX_DATA;
				end else if (s.stage == STG_ADDRR && s.ack_good && s.bytes_remaining != 8'd0) begin
					s.stage = STG_DATA;
					s.phase = PH_RX_REL;
				end else begin
					s.phase = PH_SP_SDA0;
				end
			end
			PH_RX_REL: begin
				s.sda_drive = 1'b1;
				s.shift_byte = 8'd0;
				s.bit_index = 4'd0;
				s.phase = PH_RX_SCLH;
			end
			PH_RX_SCLH: begin
				s.scl_drive = 1'b1;
				s.shift_byte = {s.shift_byte[6:0], t.sda_in};
				s.phase = PH_RX_SCLL;
			end
			PH_RX_SCLL: begin
				s.scl_drive = 1'b0;
				s.bit_index = s.bit_index + 4'd1;
				if (s.bit_index >= 4'd8) begin
					r.data_valid = 1'b1;
					r.data_byte = s.shift_byte;
					r.last_byte = (s.bytes_remaining == 8'd1);
					s.phase = PH_RA_DRV;
				end else begin
					s.phase = PH_RX_SCLH;
				end
			end
			PH_RA_DRV: begin
				s.sda_drive = (s.bytes_remaining == 8'd1);
				s.phase = PH_RA_SCLH;
			end
			PH_RA_SCLH: begin
				s.scl_drive = 1'b1;
				s.phase = PH_RA_SCLL;
			end
			PH_RA_SCLL: begin
				s.scl_drive = 1'b0;
				s.phase = PH_RA_REL;
			end
			PH_RA_REL: begin
				s.sda_drive = 1'b1;
				if (s.bytes_remaining != 8'd0)
					s.bytes_remaining = s.bytes_remaining - 8'd1;
				s.phase = (s.bytes_remaining == 8'd0) ? PH_SP_SDA0 : PH_RX_REL;
			end
			PH_SP_SDA0: begin
				s.sda_drive = 1'b0;
				s.phase = PH_SP_SCLH;
			end
			PH_SP_SCLH: begin
				s.scl_drive = 1'b1;
				s.phase = PH_SP_SDA1;
			end
			PH_SP_SDA1: begin
				s.sda_drive = 1'b1;
				r.done_res = 1'b1;
				r.success = s.ack_good;
				s.phase = PH_IDLE;
			end
			default: begin
				s.scl_drive = 1'b1;
				s.sda_drive = 1'b1;
				s.phase = PH_IDLE;
			end
		endcase
		r.scl_level = s.scl_drive;
		r.sda_level = s.sda_drive;
		r.busy_res = (s.phase != PH_IDLE);
		line_state = s;
		return r;
	endfunction

	function automatic req_t noise_tick();
		req_t t;
		t.cmd = ($urandom_range(99) < 70) ? CMD_TICK : cmd_t'($urandom_range(3));
		t.reg_addr = 8'($urandom_range(255));
		t.write_value = 8'($urandom_range(255));
		t.read_count = 8'($urandom_range(255));
		t.sda_in = 1'($urandom_range(1));
		return t;
	endfunction

	task automatic send_tick(input req_t t);
		res_t r;
		int gap;
		r = step_i2c_tick(t);
		tick_results_q.push_back(r);
		if (r.busy_res || r.done_res)
			work_ticks++;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= t.cmd;
		reg_addr <= t.reg_addr;
		write_value <= t.write_value;
		read_count <= t.read_count;
		sda_in <= t.sda_in;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic run_transfer(input cmd_t kind, input logic [7:0] reg_a, input logic [7:0] val,
			input logic [7:0] count, input int nack_pct, input bit force_nack, input stage_t nack_at);
		req_t t;
		t = noise_tick();
		t.cmd = kind;
		t.reg_addr = reg_a;
		t.write_value = val;
		t.read_count = count;
		send_tick(t);
		while (line_state.phase != PH_IDLE) begin
			t = noise_tick();
			if (line_state.phase == PH_TA_SAMP) begin
				if (force_nack && line_state.stage == nack_at)
					t.sda_in = 1'b1;
				else
					t.sda_in = ($urandom_range(99) < nack_pct);
			end
			send_tick(t);
		end
	endtask

	task automatic idle_ticks(input int n);
		req_t t;
		for (int i = 0; i < n; i++) begin
			t = noise_tick();
			t.cmd = i[0] ? CMD_RSVD : CMD_TICK;
			send_tick(t);
		end
	endtask

	task automatic settle_bus();
		in_valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_device_address(input logic [6:0] addr);
		settle_bus();
		cfg_we <= 1'b1;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		addr_shadow = addr;
	endtask

	task automatic test_reset_address();
		run_transfer(CMD_WRITE, 8'h00, 8'hFF, 8'd1, 0, 1'b0, STG_ADDRW);
		run_transfer(CMD_READ, 8'hFF, 8'h00, 8'd1, 0, 1'b0, STG_ADDRW);
	endtask

	task automatic test_address_extremes();
		logic [6:0] addrs[4];
		addrs = '{7'd8, 7'd119, 7'd85, 7'd42};
		foreach (addrs[i]) begin
			set_device_address(addrs[i]);
			run_transfer(CMD_READ, 8'h5A, 8'hA5, 8'd2, 0, 1'b0, STG_ADDRW);
		end
	endtask

	task automatic test_special_cases();
		set_device_address(DEVICE_ADDRESS_RESET);
		run_transfer(CMD_WRITE, 8'h3C, 8'hC3, 8'd0, 0, 1'b1, STG_VAL);
		run_transfer(CMD_WRITE, 8'h11, 8'h22, 8'd0, 100, 1'b0, STG_ADDRW);
		run_transfer(CMD_READ, 8'h01, 8'h00, 8'd2, 0, 1'b1, STG_ADDRW);
		run_transfer(CMD_READ, 8'h02, 8'h00, 8'd2, 0, 1'b1, STG_REG);
		run_transfer(CMD_READ, 8'h03, 8'h00, 8'd2, 0, 1'b1, STG_ADDRR);
		run_transfer(CMD_READ, 8'h04, 8'h00, 8'd0, 0, 1'b0, STG_ADDRW);
		idle_ticks(6);
		set_device_address(7'd119);
		run_transfer(CMD_READ, 8'h80, 8'h7F, 8'd6, 0, 1'b0, STG_ADDRW);
	endtask

	task automatic test_random_traffic();
		int stop_at;
		int r;
		logic [7:0] count;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				set_device_address(7'd8);
			else if (p == 1)
				set_device_address(7'd119);
			else
				set_device_address(7'($urandom_range(8, 119)));
			stalls_on = (p % 3 != 1);
			stop_at = work_ticks + RANDOM_TICKS / RANDOM_PHASES;
			while (work_ticks < stop_at) begin
				r = $urandom_range(99);
				if (r < 8) begin
					idle_ticks($urandom_range(1, 4));
				end else begin
					r = $urandom_range(99);
					if (r < 85)
						count = 8'($urandom_range(1, 4));
					else if (r < 95)
						count = 8'($urandom_range(5, 20));
					else
						count = 8'd0;
					run_transfer(($urandom_range(99) < 45) ? CMD_WRITE : CMD_READ,
						8'($urandom_range(255)), 8'($urandom_range(255)), count,
						($urandom_range(99) < 70) ? 0 : 25, 1'b0, STG_ADDRW);
				end
			end
		end
		stalls_on = 1'b1;
	endtask

	// Checks each result beat against the oldest prediction and drives the receiver stalls.
	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		int gap;
		if (arst_n && out_valid && out_ready) begin
			got = {scl_level, sda_level, busy_res, done_res, success, data_byte, data_valid,
				last_byte};
			if (tick_results_q.size() == 0) begin
				if (error_count < 10)
					$display("Unexpected result beat %0d: %s", result_count, show_result(got));
				error_count++;
			end else begin
				want = tick_results_q.pop_front();
				if (got !== want) begin
					if (error_count < 10)
						$display("Result beat %0d mismatch: expected %s, got %s", result_count,
							show_result(want), show_result(got));
					error_count++;
				end
			end
			result_count++;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			gap = pick_gap();
			out_ready <= (gap == 0);
			hold_left = (gap == 0) ? 0 : gap - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_address();
		test_address_extremes();
		test_special_cases();
		test_random_traffic();
		in_valid <= 1'b0;
		while (tick_results_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
